### hw/rtl/mlpq_pkg.sv
// shared constants and types for the multi-level priority queue
// no dependencies; imported by mlpq_ram users and the top level
package mlpq_pkg;

	localparam int LEVELS     = 8;
	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;

	localparam int LVL_W     = $clog2(LEVELS);
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int PAY_W     = 32;
	localparam int PRIO_W    = 8;
	localparam int OUT_LVL_W = 3;

	typedef enum logic [1:0] {
		ACT_PUSH    = 2'd0,
		ACT_POP_ANY = 2'd1,
		ACT_POP_LVL = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic {
		ST_IDLE,
		ST_UPD
	} state_t;

endpackage

### hw/rtl/mlpq_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module mlpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/multi_level_priority_queue.sv
// multi-level priority queue: per-level linked lists in a shared entry pool
// depends on mlpq_pkg and mlpq_ram (payload and link memories)
//
//   channel   direction  handshake            fields
//   request   in         req_valid/req_stall  action, priority_req, at_front, payload
//   result    out        res_valid/res_stall  out_payload, out_found, out_level, out_dropped
//
// a request is accepted in the idle state, which reads the pool memories; the update state
// then writes back link, payload and level pointers and loads the result.
// the write-back waits while a previous result is still stalled.
// reset is immediate: the free chain is implied by a fill count, no clearing pass.
// a new request is taken as soon as the write-back is done, even if the result waits.
module multi_level_priority_queue
	import mlpq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [1:0]              action,
	input  logic signed [PRIO_W-1:0] priority_req,
	input  logic                    at_front,
	input  logic [PAY_W-1:0]        payload,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic [PAY_W-1:0]        out_payload,
	output logic                    out_found,
	output logic [OUT_LVL_W-1:0]    out_level,
	output logic                    out_dropped
);

	state_t state_q, state_nxt;

	action_t                act_q;
	logic [LVL_W-1:0]       sel_q;
	logic                   lvl_valid_q;
	logic                   front_q;
	logic [DATA_WIDTH-1:0]  data_q;
	logic [IDX_W-1:0]       rd_addr_q;

	logic [IDX_W-1:0]       head_q [LEVELS];
	logic [IDX_W-1:0]       tail_q [LEVELS];
	logic [LEVELS-1:0]      nonempty_q;
	logic [IDX_W-1:0]       free_head_q;
	logic [CNT_W-1:0]       used_q;
	logic [CNT_W-1:0]       fill_q;

	logic                   res_valid_q;
	logic [PAY_W-1:0]       out_payload_q;
	logic                   out_found_q;
	logic [OUT_LVL_W-1:0]   out_level_q;
	logic                   out_dropped_q;

	logic                   accept;
	logic                   upd_go;
	action_t                act_in;
	logic [LVL_W-1:0]       clamp_lvl;
	logic [LVL_W-1:0]       any_lvl;
	logic [LVL_W-1:0]       sel_in;
	logic [IDX_W-1:0]       rd_addr;

	logic [DATA_WIDTH-1:0]  pay_rdata;
	logic [IDX_W-1:0]       link_rdata;
	logic [IDX_W-1:0]       link_eff;
	logic [IDX_W-1:0]       addr_succ;
	logic                   fresh;
	logic                   pool_full;

	logic                   pay_we;
	logic                   link_we;
	logic [IDX_W-1:0]       link_waddr;
	logic [IDX_W-1:0]       link_wdata;

	logic                   do_push;
	logic                   do_pop;
	logic                   push_at_head;

	logic [PAY_W-1:0]       res_payload;
	logic                   res_found;
	logic [OUT_LVL_W-1:0]   res_level;
	logic                   res_dropped;

	// request decode
	always_comb begin
		act_in = action_t'(action);
		if (priority_req[PRIO_W-1]) begin
			clamp_lvl = '0;
		end else if (int'(priority_req) >= LEVELS) begin
			clamp_lvl = LVL_W'(LEVELS - 1);
		end else begin
			clamp_lvl = LVL_W'(priority_req);
		end
		any_lvl = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				any_lvl = LVL_W'(i);
			end
		end
		sel_in  = (act_in == ACT_POP_ANY) ? any_lvl : clamp_lvl;
		rd_addr = (act_in == ACT_PUSH) ? free_head_q : head_q[sel_in];
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		req_stall = 1'b1;
		accept    = 1'b0;
		upd_go    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				accept    = req_valid;
				if (req_valid) begin
					state_nxt = ST_UPD;
				end
			end
			ST_UPD: begin
				upd_go = !res_valid_q || !res_stall;
				if (upd_go) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q       <= act_in;
			sel_q       <= sel_in;
			lvl_valid_q <= nonempty_q[sel_in];
			front_q     <= at_front;
			data_q      <= DATA_WIDTH'(payload);
			rd_addr_q   <= rd_addr;
		end
	end

	mlpq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_pay_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (rd_addr_q),
		.wdata (data_q),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (pay_rdata)
	);

	mlpq_ram #(
		.WIDTH (IDX_W),
		.DEPTH (DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (link_rdata)
	);

	// write-back decode
	always_comb begin
		pool_full    = (used_q == CNT_W'(DEPTH));
		// entries at or above the fill count were never written: free chain i -> i+1
		fresh        = (CNT_W'(rd_addr_q) >= fill_q);
		addr_succ    = (rd_addr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_addr_q + 1'b1;
		link_eff     = fresh ? addr_succ : link_rdata;
		do_push      = upd_go && (act_q == ACT_PUSH) && !pool_full;
		do_pop       = upd_go && ((act_q == ACT_POP_ANY) || (act_q == ACT_POP_LVL))
			&& lvl_valid_q;
		push_at_head = front_q || !lvl_valid_q;

		pay_we     = do_push;
		link_we    = do_push || do_pop;
		link_waddr = rd_addr_q;
		link_wdata = free_head_q;
		if (do_push) begin
			if (push_at_head) begin
				link_wdata = head_q[sel_q];
			end else begin
				link_waddr = tail_q[sel_q];
				link_wdata = rd_addr_q;
			end
		end

		res_payload = '0;
		res_found   = 1'b0;
		res_level   = OUT_LVL_W'(sel_q);
		res_dropped = 1'b0;
		unique case (act_q)
			ACT_PUSH: begin
				res_dropped = pool_full;
			end
			ACT_POP_ANY, ACT_POP_LVL: begin
				if (lvl_valid_q) begin
					res_payload = PAY_W'(pay_rdata);
					res_found   = 1'b1;
				end
			end
			ACT_NONE: begin
				res_level = '0;
			end
			default: begin
				res_level = '0;
			end
		endcase
	end

	// queue pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			nonempty_q  <= '0;
			free_head_q <= '0;
			used_q      <= '0;
			fill_q      <= '0;
		end else begin
			if (do_push) begin
				free_head_q <= link_eff;
				used_q      <= used_q + 1'b1;
				if (fresh) begin
					fill_q <= fill_q + 1'b1;
				end
				if (push_at_head) begin
					head_q[sel_q]     <= rd_addr_q;
					nonempty_q[sel_q] <= 1'b1;
					if (!lvl_valid_q) begin
						tail_q[sel_q] <= rd_addr_q;
					end
				end else begin
					tail_q[sel_q] <= rd_addr_q;
				end
			end
			if (do_pop) begin
				head_q[sel_q] <= link_eff;
				free_head_q   <= rd_addr_q;
				used_q        <= used_q - 1'b1;
				if (tail_q[sel_q] == rd_addr_q) begin
					nonempty_q[sel_q] <= 1'b0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (upd_go) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			out_payload_q <= res_payload;
			out_found_q   <= res_found;
			out_level_q   <= res_level;
			out_dropped_q <= res_dropped;
		end
	end

	assign res_valid   = res_valid_q;
	assign out_payload = out_payload_q;
	assign out_found   = out_found_q;
	assign out_level   = out_level_q;
	assign out_dropped = out_dropped_q;

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(DEPTH))
		else $error("used count above pool depth");

	a_fill_covers_used: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q >= used_q)
		else $error("fill count below used count");

	a_empty_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q == '0) |-> (nonempty_q == '0))
		else $error("level marked nonempty with no entries in use");

	a_found_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(out_found_q && out_dropped_q))
		else $error("result both found and dropped");
`endif

endmodule

### bench/multi_level_priority_queue_tb.sv
// self-checking bench for multi_level_priority_queue: directed requests, then random phases
// depends on mlpq_pkg and the rtl; the scoreboard class tracks a copy of the pool and levels
`timescale 1ns / 1ps

module multi_level_priority_queue_tb;
	import mlpq_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int HOLD_CYCLES    = 400;
	localparam int PHASES         = 10;
	localparam int PHASE_REQUESTS = 75;

	typedef struct packed {
		logic [PAY_W-1:0]     data;
		logic                 found;
		logic [OUT_LVL_W-1:0] lvl;
		logic                 dropped;
	} result_t;

	class pq_scoreboard;
		logic [PAY_W-1:0]  slot_data [DEPTH];
		logic [IDX_W-1:0]  slot_next [DEPTH];
		logic [IDX_W-1:0]  lvl_head [LEVELS];
		logic [IDX_W-1:0]  lvl_tail [LEVELS];
		logic [LEVELS-1:0] lvl_busy;
		logic [IDX_W-1:0]  free_ptr;
		int unsigned       fill;
		result_t           expected_q [$];
		int                errors;
		int                checked;

		function new();
			for (int i = 0; i < DEPTH; i++) begin
				slot_data[i] = '0;
				slot_next[i] = (i + 1 < DEPTH) ? IDX_W'(i + 1) : '0;
			end
			for (int i = 0; i < LEVELS; i++) begin
				lvl_head[i] = '0;
				lvl_tail[i] = '0;
			end
			lvl_busy = '0;
			free_ptr = '0;
			fill     = 0;
			errors   = 0;
			checked  = 0;
		endfunction

		task report(string what, logic [PAY_W-1:0] got, logic [PAY_W-1:0] want);
			$display("mismatch at result %0d, %s: got %0h, expected %0h",
				checked, what, got, want);
			errors++;
		endtask

		function int unsigned clamp_level(logic signed [PRIO_W-1:0] prio);
			int v;
			v = prio;
			if (v < 0)
				v = 0;
			if (v > LEVELS - 1)
				v = LEVELS - 1;
			return v;
		endfunction

		// unlink the level head and return its entry to the free chain
		function logic [PAY_W-1:0] take_front(int unsigned lv);
			logic [IDX_W-1:0] e;
			logic [PAY_W-1:0] d;
			e = lvl_head[lv];
			d = slot_data[e];
			if (lvl_tail[lv] == e)
				lvl_busy[lv] = 1'b0;
			lvl_head[lv] = slot_next[e];
			slot_next[e] = free_ptr;
			free_ptr = e;
			if (fill > 0)
				fill--;
			return d;
		endfunction

		function void note_request(action_t act, logic signed [PRIO_W-1:0] prio, logic front,
				logic [PAY_W-1:0] data);
			result_t r;
			int unsigned lv;
			logic [IDX_W-1:0] e;
			r = '0;
			lv = clamp_level(prio);
			case (act)
				ACT_PUSH: begin
					r.lvl = OUT_LVL_W'(lv);
					if (fill >= DEPTH) begin
						r.dropped = 1'b1;
					end else begin
						e = free_ptr;
						free_ptr = slot_next[e];
						slot_data[e] = data;
						if (front || !lvl_busy[lv]) begin
							slot_next[e] = lvl_head[lv];
							lvl_head[lv] = e;
							if (!lvl_busy[lv])
								lvl_tail[lv] = e;
							lvl_busy[lv] = 1'b1;
						end else begin
							slot_next[lvl_tail[lv]] = e;
							lvl_tail[lv] = e;
						end
						fill++;
					end
				end
				ACT_POP_ANY: begin
					for (int i = 0; i < LEVELS; i++) begin
						if (lvl_busy[i] && !r.found) begin
							r.data  = take_front(i);
							r.found = 1'b1;
							r.lvl   = OUT_LVL_W'(i);
						end
					end
				end
				ACT_POP_LVL: begin
					r.lvl = OUT_LVL_W'(lv);
					if (lvl_busy[lv]) begin
						r.data  = take_front(lv);
						r.found = 1'b1;
					end
				end
				default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report("result with no request pending", got.data, '0);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.data !== want.data)
				report("out_payload", got.data, want.data);
			if (got.found !== want.found)
				report("out_found", PAY_W'(got.found), PAY_W'(want.found));
			if (got.lvl !== want.lvl)
				report("out_level", PAY_W'(got.lvl), PAY_W'(want.lvl));
			if (got.dropped !== want.dropped)
				report("out_dropped", PAY_W'(got.dropped), PAY_W'(want.dropped));
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     req_valid;
	logic                     req_stall;
	logic [1:0]               action;
	logic signed [PRIO_W-1:0] priority_req;
	logic                     at_front;
	logic [PAY_W-1:0]         payload;
	logic                     res_valid;
	logic                     res_stall;
	logic [PAY_W-1:0]         out_payload;
	logic                     out_found;
	logic [OUT_LVL_W-1:0]     out_level;
	logic                     out_dropped;

	pq_scoreboard sb;
	int cycles;

	multi_level_priority_queue dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("multi_level_priority_queue_tb NOT OK");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_request(action_t act, logic signed [PRIO_W-1:0] prio, logic front,
			logic [PAY_W-1:0] data, bit quiet);
		int gap;
		gap = quiet ? 0 : idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action       <= act;
		priority_req <= prio;
		at_front     <= front;
		payload      <= data;
		req_valid    <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_request(act, prio, front, data);
	endtask

	task automatic send_random(int push_pct, bit quiet, output bit counted);
		action_t act;
		logic signed [PRIO_W-1:0] prio;
		if ($urandom_range(0, 99) < 4)
			act = ACT_NONE;
		else if ($urandom_range(0, 99) < push_pct)
			act = ACT_PUSH;
		else if ($urandom_range(0, 1) == 1)
			act = ACT_POP_ANY;
		else
			act = ACT_POP_LVL;
		// mostly in-range levels, sometimes the whole signed range to exercise clamping
		if ($urandom_range(0, 4) == 0)
			prio = PRIO_W'($urandom_range(0, 255));
		else
			prio = PRIO_W'($urandom_range(0, LEVELS - 1));
		send_request(act, prio, 1'($urandom_range(0, 1)), $urandom(), quiet);
		counted = (act != ACT_NONE);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() > 0);
	endtask

	// result side: random stalls, quiet stretches, and a few long hold-offs
	initial begin
		int stall_left;
		int quiet_left;
		int hold_at;
		result_t got;
		stall_left = 0;
		quiet_left = 0;
		hold_at = 150;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				got.data    = out_payload;
				got.found   = out_found;
				got.lvl     = out_level;
				got.dropped = out_dropped;
				sb.check_result(got);
				if (sb.checked == hold_at) begin
					stall_left = HOLD_CYCLES;
					hold_at += 250;
				end
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else if (quiet_left > 0) begin
				res_stall <= 1'b0;
				quiet_left--;
			end else if ($urandom_range(0, 99) < 2) begin
				quiet_left = $urandom_range(40, 120);
				res_stall <= 1'b0;
			end else begin
				stall_left = idle_len();
				res_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	initial begin
		int push_pct [PHASES];
		int sent;
		bit counted;
		bit quiet;
		push_pct = '{60, 95, 95, 40, 10, 70, 95, 95, 25, 5};
		sb = new();
		arst_n       <= 1'b0;
		req_valid    <= 1'b0;
		action       <= ACT_NONE;
		priority_req <= '0;
		at_front     <= 1'b0;
		payload      <= '0;
		res_stall    <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pops, ignored action, clamping at both ends
		send_request(ACT_POP_ANY, 8'sh00, 1'b0, '0, 1'b0);
		send_request(ACT_POP_LVL, 8'sh80, 1'b1, 32'hffff_ffff, 1'b0);
		send_request(ACT_POP_LVL, 8'sh7f, 1'b0, '0, 1'b0);
		send_request(ACT_NONE, 8'shff, 1'b1, 32'hffff_ffff, 1'b0);
		// pushes with extreme payloads, front and back linking
		send_request(ACT_PUSH, 8'sh80, 1'b0, 32'h0000_0000, 1'b0);
		send_request(ACT_PUSH, 8'sh7f, 1'b1, 32'hffff_ffff, 1'b0);
		send_request(ACT_PUSH, 8'sh08, 1'b0, 32'ha5a5_5a5a, 1'b1);
		send_request(ACT_PUSH, 8'shff, 1'b1, 32'h0000_0001, 1'b1);
		send_request(ACT_PUSH, 8'sh03, 1'b0, 32'h8000_0000, 1'b0);
		send_request(ACT_PUSH, 8'sh03, 1'b1, 32'h7fff_ffff, 1'b0);
		send_request(ACT_PUSH, 8'sh03, 1'b0, 32'h1234_5678, 1'b0);
		send_request(ACT_POP_ANY, 8'sh05, 1'b0, '0, 1'b0);
		send_request(ACT_POP_LVL, 8'sh03, 1'b0, '0, 1'b1);
		send_request(ACT_POP_LVL, 8'sh64, 1'b0, '0, 1'b1);
		// zero payload must still come out as found
		send_request(ACT_POP_ANY, 8'sh00, 1'b0, '0, 1'b0);
		send_request(ACT_POP_ANY, 8'sh00, 1'b0, '0, 1'b0);
		send_request(ACT_POP_LVL, 8'sh03, 1'b0, '0, 1'b0);
		send_request(ACT_POP_LVL, 8'sh03, 1'b0, '0, 1'b0);
		send_request(ACT_POP_ANY, 8'sh00, 1'b0, '0, 1'b0);
		send_request(ACT_POP_ANY, 8'sh00, 1'b0, '0, 1'b0);
		send_request(ACT_PUSH, 8'sh05, 1'b1, 32'h5555_5555, 1'b0);
		send_request(ACT_POP_LVL, 8'sh05, 1'b0, '0, 1'b0);
		wait_drained();

		// fill-heavy phases overflow the pool, drain-heavy ones empty it again
		for (int p = 0; p < PHASES; p++) begin
			quiet = (p % 3 == 2);
			sent = 0;
			while (sent < PHASE_REQUESTS) begin
				send_random(push_pct[p], quiet, counted);
				if (counted)
					sent++;
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("multi_level_priority_queue_tb OK");
		else
			$display("multi_level_priority_queue_tb NOT OK");
		$finish;
	end

endmodule

### multi_level_priority_queue.f
hw/rtl/mlpq_pkg.sv
hw/rtl/mlpq_ram.sv
hw/rtl/multi_level_priority_queue.sv
bench/multi_level_priority_queue_tb.sv
